>>> sv/sbie_pkg.sv
// Shared constants and types for the sixteen-bit instruction executor.
package sbie_pkg;

	localparam int STACK_WORDS_DEF = 4096;
	localparam int WORD_IDX_W      = 15;

	localparam logic [6:0] OP_ADD   = 7'd0;
	localparam logic [6:0] OP_SUB   = 7'd1;
	localparam logic [6:0] OP_AND   = 7'd2;
	localparam logic [6:0] OP_OR    = 7'd3;
	localparam logic [6:0] OP_XOR   = 7'd4;
	localparam logic [6:0] OP_NOT   = 7'd5;
	localparam logic [6:0] OP_NEG   = 7'd6;
	localparam logic [6:0] OP_MOV   = 7'd7;
	localparam logic [6:0] OP_CMP   = 7'd8;
	localparam logic [6:0] OP_PUSH  = 7'd9;
	localparam logic [6:0] OP_POP   = 7'd10;
	localparam logic [6:0] OP_JMP   = 7'd11;
	localparam logic [6:0] OP_MOVB0 = 7'd12;
	localparam logic [6:0] OP_MOVB7 = 7'd19;
	localparam logic [6:0] OP_HALT  = 7'h7F;

	localparam logic [2:0] SP_REG = 3'd7;

	typedef enum logic [3:0] {
		COND_EQ = 4'd0,
		COND_NE = 4'd1,
		COND_OS = 4'd2,
		COND_OC = 4'd3,
		COND_HI = 4'd4,
		COND_LS = 4'd5,
		COND_P  = 4'd6,
		COND_N  = 4'd7,
		COND_CS = 4'd8,
		COND_CC = 4'd9,
		COND_GE = 4'd10,
		COND_G  = 4'd11,
		COND_LE = 4'd12,
		COND_L  = 4'd13,
		COND_AL = 4'd14
	} cond_t;

	typedef struct packed {
		logic z;
		logic c;
		logic n;
		logic v;
	} flags_t;

endpackage

>>> sv/sixteen_bit_instruction_executor.sv
// Sixteen-bit instruction executor: input register, execute logic, result register, stack.
//
// Input stream s_axis: one word per instruction, the instruction and its
// immediate word. Output stream m_axis: one word per instruction with the new
// program counter, the halt mark, the Z/C/N/V flags and the executed count.
// cfg_wr_en/cfg_wr_data load the start address into the program counter; write
// it only while no instruction is in flight.
// An accepted word waits in the input register until the result register can
// take a result, is executed from there, and its result is registered.
// Throughput: one instruction per cycle for every opcode but pop, while the
// result stream does not stall. A pop holds off the input: the stack index
// (word address modulo the stack depth) goes through a registered reciprocal
// multiply, the stack memory read is registered, and the loaded word reaches
// the register file before the next instruction executes.
// Reset clears the register file, the flags, the executed count and the
// program counter; the stack memory holds no defined data until written.
// When m_axis_tready is low the result register holds and the input register
// fills, after which s_axis_tready drops until the result is taken.
module sixteen_bit_instruction_executor import sbie_pkg::*; #(
	parameter int STACK_WORDS = STACK_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [15:0] instruction_word, [31:16] immediate_word
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] next_ip, [16] halted, [17] zero_flag, [18] carry_flag,
	// [19] negative_flag, [20] overflow_flag, [52:21] executed_count, [55:53] zero
	output logic [55:0] m_axis_tdata,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	localparam int IDX_W = $clog2(STACK_WORDS);
	localparam int SH    = WORD_IDX_W + IDX_W;
	localparam longint MULT = ((longint'(1) << SH) + longint'(STACK_WORDS) - 1)
		/ longint'(STACK_WORDS);
	localparam logic [16:0] MULT_C = 17'(MULT);

	logic [15:0] pc_q;
	logic [31:0] cnt_q;
	flags_t      flags_q;
	logic [15:0] rf_q [8];

	logic        v_s1;
	logic [15:0] inst_s1;
	logic [15:0] imm_s1;

	logic        out_v_q;
	logic [15:0] out_ip_q;
	logic        out_halt_q;
	flags_t      out_flags_q;
	logic [31:0] out_cnt_q;

	logic                  stka_v_q;
	logic                  stka_pop_q;
	logic [2:0]            stka_dst_q;
	logic [WORD_IDX_W-1:0] stka_w_q;
	logic [31:0]           stka_prod_q;
	logic [15:0]           stka_data_q;

	logic        stkb_v_q;
	logic [2:0]  stkb_dst_q;
	logic [15:0] rdata_q;

	logic [15:0] stk_mem [STACK_WORDS];

	logic                  exec;
	logic                  block;
	logic                  in_fire;
	logic [6:0]            opc;
	logic [2:0]            dst;
	logic [2:0]            src;
	logic                  has_imm;
	logic [15:0]           op_a;
	logic [15:0]           op_b;
	logic [16:0]           r17;
	logic                  is_movb;
	logic                  is_push;
	logic                  is_pop;
	logic                  is_halt;
	logic                  flag_we;
	logic                  fb15;
	logic                  cond_ok;
	logic                  taken;
	flags_t                flags_nx;
	logic [15:0]           pc_nx;
	logic [15:0]           sp_dec;
	logic [15:0]           sp_inc;
	logic [2:0]            movb_dst;
	logic [WORD_IDX_W-1:0] w_a;
	logic [31:0]           prod_a;
	logic [WORD_IDX_W-1:0] q_b;
	logic [WORD_IDX_W-1:0] qn_b;
	logic [IDX_W-1:0]      idx_b;
	logic [15:0]           pop_val;

	assign exec          = v_s1 && (!out_v_q || m_axis_tready);
	assign block         = (v_s1 && is_pop) || (stka_v_q && stka_pop_q);
	assign s_axis_tready = (!v_s1 || exec) && !block;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	assign opc      = inst_s1[14:8];
	assign dst      = inst_s1[2:0];
	assign src      = inst_s1[5:3];
	assign has_imm  = inst_s1[15];
	assign is_movb  = (opc >= OP_MOVB0) && (opc <= OP_MOVB7);
	assign is_push  = (opc == OP_PUSH);
	assign is_pop   = (opc == OP_POP);
	assign is_halt  = (opc == OP_HALT);
	assign movb_dst = 3'(opc - OP_MOVB0);
	assign sp_dec   = rf_q[SP_REG] - 16'd2;
	assign sp_inc   = rf_q[SP_REG] + 16'd2;

	always_comb begin
		op_a = rf_q[dst];
		op_b = has_imm ? imm_s1 : rf_q[src];
		case (opc)
			OP_ADD:         r17 = {1'b0, op_a} + {1'b0, op_b};
			OP_SUB, OP_CMP: r17 = {1'b0, op_a} - {1'b0, op_b};
			OP_AND:         r17 = {1'b0, op_a & op_b};
			OP_OR:          r17 = {1'b0, op_a | op_b};
			OP_XOR:         r17 = {1'b0, op_a ^ op_b};
			OP_NOT:         r17 = {1'b1, ~op_a};
			OP_NEG:         r17 = 17'd0 - {1'b0, op_a};
			OP_MOV:         r17 = {1'b0, op_b};
			default:        r17 = {9'd0, inst_s1[7:0]};
		endcase
		fb15       = is_movb ? 1'b0 : op_b[15];
		flag_we    = (opc <= OP_MOV) || (opc == OP_CMP) || is_movb;
		flags_nx.z = (r17 == 17'd0);
		flags_nx.c = r17[16];
		flags_nx.n = r17[15];
		flags_nx.v = (op_a[15] == fb15) && (op_a[15] != r17[15]);
		if (!flag_we) begin
			flags_nx = flags_q;
		end
	end

	always_comb begin
		case (cond_t'(inst_s1[6:3]))
			COND_EQ: cond_ok = flags_q.z;
			COND_NE: cond_ok = !flags_q.z;
			COND_OS: cond_ok = flags_q.v;
			COND_OC: cond_ok = !flags_q.v;
			COND_HI: cond_ok = !flags_q.c && !flags_q.z;
			COND_LS: cond_ok = flags_q.c || flags_q.z;
			COND_P:  cond_ok = !flags_q.n;
			COND_N:  cond_ok = flags_q.n;
			COND_CS: cond_ok = flags_q.c;
			COND_CC: cond_ok = !flags_q.c;
			COND_GE: cond_ok = (flags_q.n == flags_q.v);
			COND_G:  cond_ok = (flags_q.n == flags_q.v) && !flags_q.z;
			COND_LE: cond_ok = (flags_q.n != flags_q.v) || flags_q.z;
			COND_L:  cond_ok = (flags_q.n != flags_q.v);
			COND_AL: cond_ok = 1'b1;
			default: cond_ok = 1'b0;
		endcase
		taken = (opc == OP_JMP) && cond_ok;
		if (is_halt) begin
			pc_nx = pc_q;
		end else if (taken) begin
			pc_nx = has_imm ? imm_s1 : op_a;
		end else begin
			pc_nx = pc_q + (has_imm ? 16'd4 : 16'd2);
		end
	end

	assign w_a    = is_push ? sp_dec[15:1] : rf_q[SP_REG][15:1];
	assign prod_a = 32'(w_a) * 32'(MULT_C);
	assign q_b    = WORD_IDX_W'(stka_prod_q >> SH);
	assign qn_b   = WORD_IDX_W'(32'(q_b) * 32'(STACK_WORDS));
	assign idx_b  = IDX_W'(stka_w_q - qn_b);
	assign pop_val = rdata_q + ((stkb_dst_q == SP_REG) ? 16'd2 : 16'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			cnt_q   <= '0;
			flags_q <= '0;
			for (int i = 0; i < 8; i++) begin
				rf_q[i] <= '0;
			end
		end else begin
			if (stkb_v_q) begin
				rf_q[stkb_dst_q] <= pop_val;
			end
			if (cfg_wr_en) begin
				pc_q    <= cfg_wr_data;
			end else if (exec) begin
				pc_q    <= pc_nx;
				cnt_q   <= cnt_q + 32'd1;
				flags_q <= flags_nx;
				if (opc <= OP_MOV) begin
					rf_q[dst] <= r17[15:0];
				end else if (is_movb) begin
					rf_q[movb_dst] <= {8'd0, inst_s1[7:0]};
				end else if (is_push) begin
					rf_q[SP_REG] <= sp_dec;
				end else if (is_pop) begin
					rf_q[SP_REG] <= sp_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			out_v_q  <= 1'b0;
			stka_v_q <= 1'b0;
			stkb_v_q <= 1'b0;
		end else begin
			if (in_fire) begin
				v_s1 <= 1'b1;
			end else if (exec) begin
				v_s1 <= 1'b0;
			end
			if (exec) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			stka_v_q <= exec && (is_push || is_pop);
			stkb_v_q <= stka_v_q && stka_pop_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			inst_s1 <= s_axis_tdata[15:0];
			imm_s1  <= s_axis_tdata[31:16];
		end
		if (exec) begin
			out_ip_q    <= pc_nx;
			out_halt_q  <= is_halt;
			out_flags_q <= flags_nx;
			out_cnt_q   <= cnt_q + 32'd1;
			stka_pop_q  <= is_pop;
			stka_dst_q  <= dst;
			stka_w_q    <= w_a;
			stka_prod_q <= prod_a;
			stka_data_q <= op_b;
		end
		stkb_dst_q <= stka_dst_q;
	end

	always_ff @(posedge clk) begin
		if (stka_v_q && !stka_pop_q) begin
			stk_mem[idx_b] <= stka_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (stka_v_q && stka_pop_q) begin
			rdata_q <= stk_mem[idx_b];
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {3'd0, out_cnt_q, out_flags_q.v, out_flags_q.n, out_flags_q.c,
		out_flags_q.z, out_halt_q, out_ip_q};

	a_pop_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		stka_v_q && stka_pop_q |-> !s_axis_tready && !v_s1)
		else $error("input taken while a pop is reading the stack");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		exec && !cfg_wr_en |=> cnt_q == $past(cnt_q) + 32'd1)
		else $error("executed count did not advance by one");

	a_halt_holds_pc: assert property (@(posedge clk) disable iff (!arst_n)
		exec && is_halt && !cfg_wr_en |=> pc_q == $past(pc_q))
		else $error("program counter moved on halt");

	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(exec))
		else $error("result appeared without an executed instruction");

	a_pop_write_alone: assert property (@(posedge clk) disable iff (!arst_n)
		stkb_v_q |-> !v_s1)
		else $error("pop load overlaps an executing instruction");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the sixteen-bit instruction executor stream.
module tb;
	import sbie_pkg::*;

	localparam int STACK_DEPTH = STACK_WORDS_DEF;
	localparam logic [3:0] COND_NEVER = 4'd15;
	localparam logic [6:0] OP_FREE_FIRST = 7'd20;
	localparam logic [6:0] OP_FREE_LAST = 7'd126;

	typedef struct packed {
		logic [31:0] count;
		logic        v;
		logic        n;
		logic        c;
		logic        z;
		logic        halted;
		logic [15:0] ip;
	} result_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;

	logic [15:0] cpu_regs[8];
	flags_t      cpu_flags;
	logic [15:0] cpu_pc;
	logic [31:0] cpu_count;
	logic [15:0] cpu_stack[STACK_DEPTH];
	bit          stack_written[STACK_DEPTH];

	result_word_t pending_results[$];

	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	int stall_request = 0;
	int stall_left = 0;
	int mismatches = 0;
	int results_checked = 0;
	int items_sent = 0;
	int jumps_taken = 0;
	int pops_done = 0;
	int halts_seen = 0;
	int address_loads = 0;

	sixteen_bit_instruction_executor uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	always #10 clk = ~clk;

	function automatic int stack_slot(input logic [15:0] sp);
		return (int'(sp) / 2) % STACK_DEPTH;
	endfunction

	function automatic void apply_flags(input logic [16:0] r, input logic [16:0] a,
			input logic [16:0] b);
		cpu_flags.z = (r == 17'd0);
		cpu_flags.c = r[16];
		cpu_flags.n = r[15];
		cpu_flags.v = (a[15] == b[15]) && (a[15] != r[15]);
	endfunction

	function automatic logic cond_holds(input logic [3:0] sel);
		case (cond_t'(sel))
			COND_EQ: return cpu_flags.z;
			COND_NE: return !cpu_flags.z;
			COND_OS: return cpu_flags.v;
			COND_OC: return !cpu_flags.v;
			COND_HI: return !cpu_flags.c && !cpu_flags.z;
			COND_LS: return cpu_flags.c || cpu_flags.z;
			COND_P:  return !cpu_flags.n;
			COND_N:  return cpu_flags.n;
			COND_CS: return cpu_flags.c;
			COND_CC: return !cpu_flags.c;
			COND_GE: return cpu_flags.n == cpu_flags.v;
			COND_G:  return (cpu_flags.n == cpu_flags.v) && !cpu_flags.z;
			COND_LE: return (cpu_flags.n != cpu_flags.v) || cpu_flags.z;
			COND_L:  return cpu_flags.n != cpu_flags.v;
			COND_AL: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void step_machine(input logic [15:0] iw, input logic [15:0] imm);
		logic [6:0]   opc;
		logic [2:0]   dst;
		logic [2:0]   tgt;
		logic         use_imm;
		logic         halt;
		logic         taken;
		logic [16:0]  a;
		logic [16:0]  b;
		logic [16:0]  r;
		logic [16:0]  byte_val;
		int           slot;
		result_word_t res;
		opc = iw[14:8];
		dst = iw[2:0];
		use_imm = iw[15];
		a = {1'b0, cpu_regs[dst]};
		b = use_imm ? {1'b0, imm} : {1'b0, cpu_regs[iw[5:3]]};
		halt = 1'b0;
		taken = 1'b0;
		cpu_count = cpu_count + 32'd1;
		if (opc >= OP_MOVB0 && opc <= OP_MOVB7) begin
			tgt = 3'(opc - OP_MOVB0);
			byte_val = {9'd0, iw[7:0]};
			cpu_regs[tgt] = byte_val[15:0];
			apply_flags(byte_val, a, byte_val);
		end else begin
			case (opc)
				OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NOT, OP_NEG, OP_MOV: begin
					case (opc)
						OP_ADD:  r = a + b;
						OP_SUB:  r = a - b;
						OP_AND:  r = a & b;
						OP_OR:   r = a | b;
						OP_XOR:  r = a ^ b;
						OP_NOT:  r = ~a;
						OP_NEG:  r = 17'd0 - a;
						default: r = b;
					endcase
					cpu_regs[dst] = r[15:0];
					apply_flags(r, a, b);
				end
				OP_CMP: begin
					r = a - b;
					apply_flags(r, a, b);
				end
				OP_PUSH: begin
					cpu_regs[SP_REG] = cpu_regs[SP_REG] - 16'd2;
					slot = stack_slot(cpu_regs[SP_REG]);
					cpu_stack[slot] = b[15:0];
					stack_written[slot] = 1'b1;
				end
				OP_POP: begin
					cpu_regs[dst] = cpu_stack[stack_slot(cpu_regs[SP_REG])];
					cpu_regs[SP_REG] = cpu_regs[SP_REG] + 16'd2;
					pops_done++;
				end
				OP_JMP: begin
					if (cond_holds(iw[6:3])) begin
						cpu_pc = use_imm ? imm : a[15:0];
						taken = 1'b1;
						jumps_taken++;
					end
				end
				OP_HALT: begin
					halt = 1'b1;
					halts_seen++;
				end
				default: ;
			endcase
		end
		if (!halt && !taken)
			cpu_pc = cpu_pc + (use_imm ? 16'd4 : 16'd2);
		res.ip = cpu_pc;
		res.halted = halt;
		res.z = cpu_flags.z;
		res.c = cpu_flags.c;
		res.n = cpu_flags.n;
		res.v = cpu_flags.v;
		res.count = cpu_count;
		pending_results.push_back(res);
	endfunction

	function automatic void check_result(input logic [55:0] word);
		result_word_t got;
		result_word_t want;
		got = result_word_t'(word[52:0]);
		if (pending_results.size() == 0) begin
			$error("result word with nothing pending: %h", word);
			mismatches++;
		end else begin
			want = pending_results.pop_front();
			results_checked++;
			if (got.ip !== want.ip) begin
				$error("next_ip: expected %h, got %h", want.ip, got.ip);
				mismatches++;
			end
			if (got.halted !== want.halted) begin
				$error("halted: expected %b, got %b", want.halted, got.halted);
				mismatches++;
			end
			if (got.z !== want.z) begin
				$error("zero_flag: expected %b, got %b", want.z, got.z);
				mismatches++;
			end
			if (got.c !== want.c) begin
				$error("carry_flag: expected %b, got %b", want.c, got.c);
				mismatches++;
			end
			if (got.n !== want.n) begin
				$error("negative_flag: expected %b, got %b", want.n, got.n);
				mismatches++;
			end
			if (got.v !== want.v) begin
				$error("overflow_flag: expected %b, got %b", want.v, got.v);
				mismatches++;
			end
			if (got.count !== want.count) begin
				$error("executed_count: expected %0d, got %0d", want.count, got.count);
				mismatches++;
			end
		end
	endfunction

	// result side: check, then pick next ready
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_result(m_axis_tdata);
		if (stall_request > 0) begin
			stall_left = stall_request;
			stall_request = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (rx_idle_en) begin
			m_axis_tready <= ($urandom_range(99) >= 31);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic issue_instruction(input logic [15:0] iw, input logic [15:0] imm);
		while (tx_idle_en && $urandom_range(99) < 31) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {imm, iw};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		step_machine(iw, imm);
		items_sent++;
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_start_address(input logic [15:0] addr);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= addr;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cpu_pc = addr;
		address_loads++;
	endtask

	function automatic logic [15:0] pick_immediate();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void pick_instruction(output logic [15:0] iw, output logic [15:0] imm);
		logic [6:0] opc;
		logic [2:0] dst;
		int         sel;
		sel = $urandom_range(99);
		if (sel < 12)
			opc = 7'($urandom_range(OP_MOVB7, OP_MOVB0));
		else if (sel < 52)
			opc = 7'($urandom_range(OP_MOV, OP_ADD));
		else if (sel < 60)
			opc = OP_CMP;
		else if (sel < 71)
			opc = OP_PUSH;
		else if (sel < 82)
			opc = OP_POP;
		else if (sel < 95)
			opc = OP_JMP;
		else if (sel < 97)
			opc = OP_HALT;
		else
			opc = 7'($urandom_range(OP_FREE_LAST, OP_FREE_FIRST));
		// never read a stack word that was not pushed
		if (opc == OP_POP && !stack_written[stack_slot(cpu_regs[SP_REG])])
			opc = OP_PUSH;
		dst = 3'($urandom_range(7));
		// keep the stack pointer alive most of the time
		if (opc <= OP_MOV && dst == SP_REG && $urandom_range(3) != 0)
			dst = 3'($urandom_range(6));
		iw = {1'($urandom_range(1)), opc, 5'($urandom_range(31)), dst};
		imm = pick_immediate();
	endfunction

	task automatic run_random(input int count);
		logic [15:0] iw;
		logic [15:0] imm;
		for (int i = 0; i < count; i++) begin
			pick_instruction(iw, imm);
			issue_instruction(iw, imm);
		end
	endtask

	task automatic test_alu_flags();
		load_start_address(16'hFFFF);
		issue_instruction({1'b0, OP_MOVB0, 8'hFF}, 16'h0000);
		issue_instruction({1'b1, OP_MOV, 5'd0, 3'd1}, 16'hFFFF);
		issue_instruction({1'b1, OP_ADD, 5'd0, 3'd1}, 16'h0001);
		issue_instruction({1'b1, OP_SUB, 5'd0, 3'd1}, 16'h0001);
		issue_instruction({1'b0, OP_NEG, 5'd0, 3'd1}, 16'h0000);
		issue_instruction({1'b0, OP_NOT, 5'd0, 3'd0}, 16'h0000);
	endtask

	task automatic test_stack_wrap();
		issue_instruction({1'b1, OP_PUSH, 5'd0, 3'd0}, 16'hA5A5);
		issue_instruction({1'b0, OP_PUSH, 5'd0, 3'd0}, 16'h0000);
		issue_instruction({1'b0, OP_POP, 5'd0, SP_REG}, 16'h0000);
	endtask

	task automatic test_conditions();
		logic [3:0] c;
		for (int i = 0; i <= COND_NEVER; i++) begin
			c = 4'(i);
			if (c[0])
				issue_instruction({1'b0, OP_JMP, 1'b0, c, c[2:0]}, 16'h0000);
			else
				issue_instruction({1'b1, OP_JMP, 1'b1, c, c[2:0]}, pick_immediate());
		end
	endtask

	task automatic test_halt_and_unused();
		issue_instruction({1'b0, OP_HALT, 8'h00}, 16'h0000);
		issue_instruction({1'b1, OP_FREE_LAST, 8'hFF}, 16'hFFFF);
	endtask

	task automatic test_random_mix();
		load_start_address(16'h0000);
		run_random(90);
		// a long stretch with no idling on either side
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		load_start_address(16'($urandom));
		run_random(90);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		load_start_address(16'hFFFF);
		run_random(90);
		load_start_address(16'($urandom));
		run_random(90);
	endtask

	task automatic test_backpressure();
		drain_results();
		stall_request = 150;
		run_random(40);
		drain_results();
	endtask

	initial begin
		foreach (cpu_regs[i])
			cpu_regs[i] = 16'h0000;
		foreach (stack_written[i])
			stack_written[i] = 1'b0;
		cpu_flags = '0;
		cpu_pc = 16'h0000;
		cpu_count = 32'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_alu_flags();
		test_stack_wrap();
		test_conditions();
		test_halt_and_unused();
		test_random_mix();
		test_backpressure();
		drain_results();
		$display("Ran %0d instructions: %0d jumps taken, %0d pops, %0d halts, %0d loads.",
			items_sent, jumps_taken, pops_done, halts_seen, address_loads);
		$display("Compared %0d result words field by field, %0d mismatches.",
			results_checked, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
